### rtl/core/jsv_pkg.sv
`default_nettype none
package jsv_pkg;

    localparam logic [4:0] EV_SKIP     = 5'd0;
    localparam logic [4:0] EV_OBJOPEN  = 5'd1;
    localparam logic [4:0] EV_OBJCLOSE = 5'd2;
    localparam logic [4:0] EV_ARROPEN  = 5'd3;
    localparam logic [4:0] EV_ARRCLOSE = 5'd4;
    localparam logic [4:0] EV_STRSTART = 5'd5;
    localparam logic [4:0] EV_CHAR     = 5'd6;
    localparam logic [4:0] EV_STREND   = 5'd7;
    localparam logic [4:0] EV_COLON    = 5'd8;
    localparam logic [4:0] EV_COMMA    = 5'd9;
    localparam logic [4:0] EV_LITCHAR  = 5'd10;
    localparam logic [4:0] EV_NUMCHAR  = 5'd14;
    localparam logic [4:0] EV_ESCAPE   = 5'd15;
    localparam logic [4:0] EV_DONE     = 5'd16;
    localparam logic [4:0] EV_ERROR    = 5'd17;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_VALSTART  = 4'd1;
    localparam logic [3:0] ERR_SEP       = 4'd2;
    localparam logic [3:0] ERR_NUMBER    = 4'd3;
    localparam logic [3:0] ERR_ESCAPE    = 4'd4;
    localparam logic [3:0] ERR_UNICODE   = 4'd5;
    localparam logic [3:0] ERR_EARLY_END = 4'd6;
    localparam logic [3:0] ERR_EXTRA     = 4'd7;
    localparam logic [3:0] ERR_TOO_DEEP  = 4'd8;
    localparam logic [3:0] ERR_LITERAL   = 4'd9;

    localparam logic [3:0] M_TOP       = 4'd0;
    localparam logic [3:0] M_VALUE     = 4'd1;
    localparam logic [3:0] M_ARR_FIRST = 4'd2;
    localparam logic [3:0] M_OBJ_FIRST = 4'd3;
    localparam logic [3:0] M_KEY       = 4'd4;
    localparam logic [3:0] M_COLON     = 4'd5;
    localparam logic [3:0] M_AFTER     = 4'd6;
    localparam logic [3:0] M_STRING    = 4'd7;
    localparam logic [3:0] M_ESCAPE    = 4'd8;
    localparam logic [3:0] M_LITERAL   = 4'd9;
    localparam logic [3:0] M_NUMBER    = 4'd10;

    // byte classes found by the front end
    localparam logic [3:0] C_OTHER  = 4'd0;
    localparam logic [3:0] C_WS     = 4'd1;
    localparam logic [3:0] C_LBRACE = 4'd2;
    localparam logic [3:0] C_RBRACE = 4'd3;
    localparam logic [3:0] C_LBRACK = 4'd4;
    localparam logic [3:0] C_RBRACK = 4'd5;
    localparam logic [3:0] C_QUOTE  = 4'd6;
    localparam logic [3:0] C_BSLASH = 4'd7;
    localparam logic [3:0] C_COLON  = 4'd8;
    localparam logic [3:0] C_COMMA  = 4'd9;
    localparam logic [3:0] C_MINUS  = 4'd10;
    localparam logic [3:0] C_ZERO   = 4'd11;
    localparam logic [3:0] C_DIGIT  = 4'd12;
    localparam logic [3:0] C_DOT    = 4'd13;
    localparam logic [3:0] C_EXP    = 4'd14;
    localparam logic [3:0] C_PLUS   = 4'd15;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
        logic [3:0] cls;
    } t_item;

    typedef struct packed {
        logic [4:0] event_res;
        logic [7:0] char_value;
        logic       is_key;
        logic [6:0] nesting_depth;
        logic       number_done;
        logic       number_is_real;
        logic [3:0] error_code;
        logic       document_done;
    } t_result;

    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'd0;
        unique case (kind)
            2'd1: unique case (idx)
                3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
                default: c = 8'd0;
            endcase
            2'd2: unique case (idx)
                3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
                3'd4: c = "e";
                default: c = 8'd0;
            endcase
            2'd3: unique case (idx)
                3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
                default: c = 8'd0;
            endcase
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        logic [2:0] n;
        unique case (kind)
            2'd1: n = 3'd4;
            2'd2: n = 3'd5;
            2'd3: n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

### rtl/core/json_stream_validator_unit.sv
// Streaming JSON validator: one text byte per transfer in, one event per transfer out,
// sustained at one byte per clock as long as each event is popped. A byte is classified
// and queued in a two-entry front queue, then the parser stage updates its mode and
// container stack and registers the event in its output register. The parser step
// (mode update plus a registered top-of-stack bit) sets the rate.
// The user must write the depth limit register only while the block is idle; the block
// itself does not enforce this. The effective limit is min(depth_limit, MAX_NESTING).
`default_nettype none
module json_stream_validator_unit #(
    parameter int MAX_NESTING = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_end_of_text,
    output logic            empty,
    input  wire logic       pop,
    output logic [4:0]      o_event_res,
    output logic [7:0]      o_char_value,
    output logic            o_is_key,
    output logic [6:0]      o_nesting_depth,
    output logic            o_number_done,
    output logic            o_number_is_real,
    output logic [3:0]      o_error_code,
    output logic            o_document_done,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_data
);
    jsv_pkg::t_item   item;
    jsv_pkg::t_result res;
    logic             item_vld, take;

    jsv_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_text_byte(i_text_byte), .i_end_of_text(i_end_of_text),
        .o_item(item), .o_valid(item_vld), .i_take(take)
    );

    jsv_back #(.MAX_NESTING(MAX_NESTING)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_item(item), .i_valid(item_vld), .o_take(take),
        .o_res(res), .o_empty(empty), .i_pop(pop)
    );

    assign o_event_res      = res.event_res;
    assign o_char_value     = res.char_value;
    assign o_is_key         = res.is_key;
    assign o_nesting_depth  = res.nesting_depth;
    assign o_number_done    = res.number_done;
    assign o_number_is_real = res.number_is_real;
    assign o_error_code     = res.error_code;
    assign o_document_done  = res.document_done;
endmodule
`default_nettype wire

### rtl/core/jsv_front.sv
`default_nettype none
module jsv_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_full,
    input  wire logic [7:0]      i_text_byte,
    input  wire logic            i_end_of_text,
    output jsv_pkg::t_item       o_item,
    output logic                 o_valid,
    input  wire logic            i_take
);
    // two-entry queue of classified bytes
    jsv_pkg::t_item r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, r_wr;
    logic [3:0] cls;
    logic       wr_en, rd_en;

    always_comb begin
        priority case (i_text_byte)
            8'h20, 8'h09, 8'h0a, 8'h0d: cls = jsv_pkg::C_WS;
            "{": cls = jsv_pkg::C_LBRACE;
            "}": cls = jsv_pkg::C_RBRACE;
            "[": cls = jsv_pkg::C_LBRACK;
            "]": cls = jsv_pkg::C_RBRACK;
            8'h22: cls = jsv_pkg::C_QUOTE;
            8'h5c: cls = jsv_pkg::C_BSLASH;
            ":": cls = jsv_pkg::C_COLON;
            ",": cls = jsv_pkg::C_COMMA;
            "-": cls = jsv_pkg::C_MINUS;
            "+": cls = jsv_pkg::C_PLUS;
            "0": cls = jsv_pkg::C_ZERO;
            "1", "2", "3", "4", "5", "6", "7", "8", "9": cls = jsv_pkg::C_DIGIT;
            ".": cls = jsv_pkg::C_DOT;
            "e", "E": cls = jsv_pkg::C_EXP;
            default: cls = jsv_pkg::C_OTHER;
        endcase
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_take && o_valid;
    assign n_cnt   = r_cnt + {1'b0, wr_en} - {1'b0, rd_en};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (wr_en) r_wr <= ~r_wr;
            if (rd_en) r_rd <= ~r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= '{text_byte: i_text_byte, end_of_text: i_end_of_text, cls: cls};
        end
    end

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) (r_cnt == 2'd2) |-> !wr_en || rd_en;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("front queue overflow");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("front queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_rd == r_wr)
        else $error("front queue pointers disagree with count");
endmodule
`default_nettype wire

### rtl/core/jsv_back.sv
`default_nettype none
module jsv_back #(
    parameter int MAX_NESTING = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [6:0]      i_cfg_data,
    input  jsv_pkg::t_item       i_item,
    input  wire logic            i_valid,
    output logic                 o_take,
    output jsv_pkg::t_result     o_res,
    output logic                 o_empty,
    input  wire logic            i_pop
);
    localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
    localparam int DW = $clog2(MAX_NESTING + 1);

    logic             r_stack [MAX_NESTING];
    logic [DW-1:0]    r_depth, n_depth;
    logic [3:0]       r_mode, n_mode;
    logic [1:0]       r_lkind, n_lkind;
    logic [2:0]       r_lidx, n_lidx;
    logic [2:0]       r_nph, n_nph;
    logic             r_nreal, n_nreal;
    logic             r_inkey, n_inkey;
    logic             r_err, n_err;
    logic [6:0]       r_limit;
    logic             r_out_vld;
    jsv_pkg::t_result r_out, res;
    logic             push_en, push_val, pop_en;
    logic [AW-1:0]    push_idx, rd_idx;
    logic             r_top, r_below;
    logic             top_obj;
    logic             step;

    assign o_empty = !r_out_vld;
    assign o_res   = r_out;
    assign o_take  = !r_out_vld || i_pop;
    assign step    = i_valid && o_take;
    assign push_idx = AW'(r_depth);
    // entry two below the top, fetched when a close exposes the next one
    assign rd_idx  = AW'(r_depth - DW'(3));
    assign top_obj = r_top;

    always_comb begin
        logic [7:0] c;
        logic [3:0] k;
        logic       ws, val_path, after_path, num_ok, open_ok;
        logic [2:0] nx;
        logic [DW:0] lim;
        c = i_item.text_byte;
        k = i_item.cls;
        ws = (k == jsv_pkg::C_WS);
        res = '0;
        n_depth = r_depth; n_mode = r_mode; n_lkind = r_lkind; n_lidx = r_lidx;
        n_nph = r_nph; n_nreal = r_nreal; n_inkey = r_inkey; n_err = r_err;
        push_en = 1'b0; push_val = 1'b0; pop_en = 1'b0;
        val_path = 1'b0; after_path = 1'b0;
        nx = 3'd0; num_ok = 1'b0;
        lim = (int'(r_limit) > MAX_NESTING) ? (DW+1)'(MAX_NESTING) : (DW+1)'(r_limit);
        open_ok = ({1'b0, r_depth} < lim);

        if (i_item.end_of_text) begin
            if (r_err) begin
                res.event_res = jsv_pkg::EV_DONE;
            end else if (r_depth == '0 && r_mode == jsv_pkg::M_AFTER) begin
                res.event_res = jsv_pkg::EV_DONE;
                res.document_done = 1'b1;
            end else if (r_depth == '0 && r_mode == jsv_pkg::M_NUMBER &&
                         (r_nph == 3'd1 || r_nph == 3'd2 || r_nph == 3'd4 || r_nph == 3'd7)) begin
                res.event_res = jsv_pkg::EV_DONE;
                res.document_done = 1'b1;
                res.number_done = 1'b1;
                res.number_is_real = r_nreal;
            end else begin
                res.event_res = jsv_pkg::EV_ERROR;
                res.error_code = jsv_pkg::ERR_EARLY_END;
            end
            n_mode = jsv_pkg::M_TOP; n_depth = '0; n_lkind = '0; n_lidx = '0;
            n_nph = '0; n_nreal = 1'b0; n_inkey = 1'b0; n_err = 1'b0;
        end else if (!r_err) begin
            unique case (r_mode)
                jsv_pkg::M_TOP, jsv_pkg::M_VALUE: val_path = 1'b1;
                jsv_pkg::M_ARR_FIRST: begin
                    if (k == jsv_pkg::C_RBRACK) begin
                        n_depth = r_depth - DW'(1);
                        pop_en = 1'b1;
                        res.event_res = top_obj ? jsv_pkg::EV_OBJCLOSE : jsv_pkg::EV_ARRCLOSE;
                        n_mode = jsv_pkg::M_AFTER;
                    end else val_path = 1'b1;
                end
                jsv_pkg::M_OBJ_FIRST, jsv_pkg::M_KEY: begin
                    if (r_mode == jsv_pkg::M_OBJ_FIRST && k == jsv_pkg::C_RBRACE) begin
                        n_depth = r_depth - DW'(1);
                        pop_en = 1'b1;
                        res.event_res = top_obj ? jsv_pkg::EV_OBJCLOSE : jsv_pkg::EV_ARRCLOSE;
                        n_mode = jsv_pkg::M_AFTER;
                    end else if (k == jsv_pkg::C_QUOTE) begin
                        n_inkey = 1'b1;
                        res.event_res = jsv_pkg::EV_STRSTART;
                        res.is_key = 1'b1;
                        n_mode = jsv_pkg::M_STRING;
                    end else if (!ws) begin
                        res.event_res = jsv_pkg::EV_ERROR;
                        res.error_code = jsv_pkg::ERR_SEP;
                        n_err = 1'b1;
                    end
                end
                jsv_pkg::M_COLON: begin
                    if (k == jsv_pkg::C_COLON) begin
                        res.event_res = jsv_pkg::EV_COLON;
                        n_mode = jsv_pkg::M_VALUE;
                    end else if (!ws) begin
                        res.event_res = jsv_pkg::EV_ERROR;
                        res.error_code = jsv_pkg::ERR_SEP;
                        n_err = 1'b1;
                    end
                end
                jsv_pkg::M_AFTER: after_path = 1'b1;
                jsv_pkg::M_STRING: begin
                    res.is_key = r_inkey;
                    if (k == jsv_pkg::C_BSLASH) begin
                        res.event_res = jsv_pkg::EV_ESCAPE;
                        n_mode = jsv_pkg::M_ESCAPE;
                    end else if (k == jsv_pkg::C_QUOTE) begin
                        res.event_res = jsv_pkg::EV_STREND;
                        n_mode = r_inkey ? jsv_pkg::M_COLON : jsv_pkg::M_AFTER;
                        n_inkey = 1'b0;
                    end else begin
                        res.event_res = jsv_pkg::EV_CHAR;
                        res.char_value = c;
                    end
                end
                jsv_pkg::M_ESCAPE: begin
                    res.event_res = jsv_pkg::EV_CHAR;
                    res.is_key = r_inkey;
                    n_mode = jsv_pkg::M_STRING;
                    priority case (c)
                        8'h22, 8'h5c, "/": res.char_value = c;
                        "b": res.char_value = 8'h08;
                        "f": res.char_value = 8'h0c;
                        "n": res.char_value = 8'h0a;
                        "r": res.char_value = 8'h0d;
                        "t": res.char_value = 8'h09;
                        default: begin
                            res = '0;
                            res.event_res = jsv_pkg::EV_ERROR;
                            res.error_code = (c == "u") ? jsv_pkg::ERR_UNICODE
                                                        : jsv_pkg::ERR_ESCAPE;
                            n_err = 1'b1;
                            n_mode = r_mode;
                        end
                    endcase
                end
                jsv_pkg::M_LITERAL: begin
                    if (r_lkind == 2'd0 || r_lidx >= jsv_pkg::lit_len(r_lkind) ||
                        c != jsv_pkg::lit_char(r_lkind, r_lidx)) begin
                        res.event_res = jsv_pkg::EV_ERROR;
                        res.error_code = jsv_pkg::ERR_LITERAL;
                        n_err = 1'b1;
                    end else if (r_lidx + 3'd1 == jsv_pkg::lit_len(r_lkind)) begin
                        res.event_res = jsv_pkg::EV_LITCHAR + {3'd0, r_lkind};
                        n_lkind = '0; n_lidx = '0;
                        n_mode = jsv_pkg::M_AFTER;
                    end else begin
                        res.event_res = jsv_pkg::EV_LITCHAR;
                        n_lidx = r_lidx + 3'd1;
                    end
                end
                jsv_pkg::M_NUMBER: begin
                    num_ok = 1'b1;
                    unique case (r_nph)
                        3'd0: if (k == jsv_pkg::C_ZERO) nx = 3'd1;
                              else if (k == jsv_pkg::C_DIGIT) nx = 3'd2;
                              else num_ok = 1'b0;
                        3'd6: if (k == jsv_pkg::C_ZERO || k == jsv_pkg::C_DIGIT) nx = 3'd7;
                              else num_ok = 1'b0;
                        3'd3: if (k == jsv_pkg::C_ZERO || k == jsv_pkg::C_DIGIT) nx = 3'd4;
                              else num_ok = 1'b0;
                        3'd5: if (k == jsv_pkg::C_PLUS || k == jsv_pkg::C_MINUS) nx = 3'd6;
                              else if (k == jsv_pkg::C_ZERO || k == jsv_pkg::C_DIGIT) nx = 3'd7;
                              else num_ok = 1'b0;
                        default: begin
                            if ((k == jsv_pkg::C_ZERO || k == jsv_pkg::C_DIGIT) && r_nph != 3'd1)
                                nx = r_nph;
                            else if (k == jsv_pkg::C_DOT && (r_nph == 3'd1 || r_nph == 3'd2))
                                nx = 3'd3;
                            else if (k == jsv_pkg::C_EXP && r_nph != 3'd7)
                                nx = 3'd5;
                            else num_ok = 1'b0;
                        end
                    endcase
                    if (num_ok) begin
                        if (nx == 3'd3 || nx == 3'd5) n_nreal = 1'b1;
                        n_nph = nx;
                        res.event_res = jsv_pkg::EV_NUMCHAR;
                    end else if (!(r_nph == 3'd1 || r_nph == 3'd2 || r_nph == 3'd4 ||
                                   r_nph == 3'd7)) begin
                        res.event_res = jsv_pkg::EV_ERROR;
                        res.error_code = jsv_pkg::ERR_NUMBER;
                        n_err = 1'b1;
                    end else begin
                        res.number_done = 1'b1;
                        res.number_is_real = r_nreal;
                        n_mode = jsv_pkg::M_AFTER;
                        after_path = 1'b1;
                    end
                end
                default: begin
                    res.event_res = jsv_pkg::EV_ERROR;
                    res.error_code = jsv_pkg::ERR_VALSTART;
                    n_err = 1'b1;
                end
            endcase

            if (val_path && !ws) begin
                priority case (k)
                    jsv_pkg::C_LBRACE, jsv_pkg::C_LBRACK: begin
                        if (!open_ok) begin
                            res.event_res = jsv_pkg::EV_ERROR;
                            res.error_code = jsv_pkg::ERR_TOO_DEEP;
                            n_err = 1'b1;
                        end else begin
                            push_en = 1'b1;
                            push_val = (k == jsv_pkg::C_LBRACE);
                            n_depth = r_depth + DW'(1);
                            res.event_res = push_val ? jsv_pkg::EV_OBJOPEN
                                                     : jsv_pkg::EV_ARROPEN;
                            n_mode = push_val ? jsv_pkg::M_OBJ_FIRST : jsv_pkg::M_ARR_FIRST;
                        end
                    end
                    jsv_pkg::C_QUOTE: begin
                        n_inkey = 1'b0;
                        res.event_res = jsv_pkg::EV_STRSTART;
                        n_mode = jsv_pkg::M_STRING;
                    end
                    jsv_pkg::C_MINUS, jsv_pkg::C_ZERO, jsv_pkg::C_DIGIT: begin
                        n_nph = (k == jsv_pkg::C_MINUS) ? 3'd0 :
                                (k == jsv_pkg::C_ZERO) ? 3'd1 : 3'd2;
                        n_nreal = 1'b0;
                        res.event_res = jsv_pkg::EV_NUMCHAR;
                        n_mode = jsv_pkg::M_NUMBER;
                    end
                    default: begin
                        if (c == "t" || c == "f" || c == "n") begin
                            n_lkind = (c == "t") ? 2'd1 : (c == "f") ? 2'd2 : 2'd3;
                            n_lidx = 3'd1;
                            res.event_res = jsv_pkg::EV_LITCHAR;
                            n_mode = jsv_pkg::M_LITERAL;
                        end else begin
                            res.event_res = jsv_pkg::EV_ERROR;
                            res.error_code = jsv_pkg::ERR_VALSTART;
                            n_err = 1'b1;
                        end
                    end
                endcase
            end

            if (after_path && !ws) begin
                if (r_depth == '0) begin
                    res.event_res = jsv_pkg::EV_ERROR;
                    res.error_code = jsv_pkg::ERR_EXTRA;
                    n_err = 1'b1;
                end else if (k == jsv_pkg::C_COMMA) begin
                    res.event_res = jsv_pkg::EV_COMMA;
                    n_mode = top_obj ? jsv_pkg::M_KEY : jsv_pkg::M_VALUE;
                end else if ((k == jsv_pkg::C_RBRACE && top_obj) ||
                             (k == jsv_pkg::C_RBRACK && !top_obj)) begin
                    n_depth = r_depth - DW'(1);
                    pop_en = 1'b1;
                    res.event_res = top_obj ? jsv_pkg::EV_OBJCLOSE : jsv_pkg::EV_ARRCLOSE;
                    n_mode = jsv_pkg::M_AFTER;
                end else begin
                    res.event_res = jsv_pkg::EV_ERROR;
                    res.error_code = jsv_pkg::ERR_SEP;
                    n_err = 1'b1;
                end
            end
        end
        res.nesting_depth = 7'(n_depth);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0; r_mode <= jsv_pkg::M_TOP; r_lkind <= '0; r_lidx <= '0;
            r_nph <= '0; r_nreal <= 1'b0; r_inkey <= 1'b0; r_err <= 1'b0;
            r_limit <= 7'd64;
            r_out_vld <= 1'b0;
            r_top <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            if (step) begin
                r_depth <= n_depth; r_mode <= n_mode; r_lkind <= n_lkind;
                r_lidx <= n_lidx; r_nph <= n_nph; r_nreal <= n_nreal;
                r_inkey <= n_inkey; r_err <= n_err;
                if (push_en) r_top <= push_val;
                else if (pop_en) r_top <= r_below;
            end
            if (step) r_out_vld <= 1'b1;
            else if (i_pop) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) r_out <= res;
        // keep the entry under the top ready for the next close
        if (step && push_en) begin
            r_stack[push_idx] <= push_val;
            r_below <= r_top;
        end else if (step && pop_en) begin
            r_below <= r_stack[rd_idx];
        end
    end

    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_depth} <= (DW+1)'(MAX_NESTING))
        else $error("nesting depth above maximum");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_pop) |=> r_out_vld && $stable(r_out))
        else $error("result changed while waiting");

    a_error_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_err && !i_item.end_of_text) |-> res.event_res == jsv_pkg::EV_SKIP)
        else $error("byte after error not skipped");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && i_item.end_of_text) |=> r_depth == '0 && !r_err && r_mode == jsv_pkg::M_TOP)
        else $error("end marker did not reset parser");
endmodule
`default_nettype wire
